FILE: rtl/core/pfg_pkg.sv
`timescale 1ns / 1ps

package pfg_pkg;

    localparam int LEVEL_W       = 8;
    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = 8;
    localparam int FADE_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    // Item function codes; the fourth code is unused and ignored
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_GAMMA = 2'd2
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FADE_TIME       = 2'd0,
        REG_GAMMA_ENABLE    = 2'd1,
        REG_OUTPUT_ATTACHED = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        func_t                func;
        logic [LEVEL_W-1:0]   level;
        logic [TABLE_AW-1:0]  table_index;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty;
        logic [LEVEL_W-1:0] linear_level;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTERP,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_CHECK,
        ST_LOOK,
        ST_EMIT
    } state_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/core/pfg_ram.sv
`timescale 1ns / 1ps

module pfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/pfg_div.sv
`timescale 1ns / 1ps

module pfg_div
    import pfg_pkg::*;
#(
    parameter int DVD_W = 24,
    parameter int DVS_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output div_stat_t        stat
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_shift;
    logic             fits;
    logic [DVS_W:0]   rem_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    // Control: count one step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(DVD_W - 1);
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Datapath: quotient bits shift in behind the dividend bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (count_reg == '0);
    assign quotient  = {dvd_reg[DVD_W-2:0], fits};

    // The remainder always stays below the divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

endmodule

FILE: rtl/core/pwm_fade_with_gamma.sv
`timescale 1ns / 1ps

// LED fade engine with gamma correction. A set item stores the target level; with a
// zero fade time or a detached output the level jumps there at once (a result goes
// out only when attached), otherwise a fade restarts from the present level. Each
// tick item counts one millisecond and moves the level to
// start + (target - start) * elapsed / fade_time, emitting a result when the level
// changes; duty is the gamma table entry for the level when gamma is enabled. A gamma
// item writes one table entry, which must be written before gamma reads it. A tick
// that interpolates runs the one-bit-per-cycle divider over the 8 + TIME_BITS bit
// product; a tick at or past the end of the fade skips the divider. An emitting
// set goes straight to the table read. An emitting item waits further while the
// previous result has not been taken. The block takes no new item while a tick or
// emit is in progress; one finished result waits in the output register while the
// next item is taken.
module pwm_fade_with_gamma
    import pfg_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PROD_W = LEVEL_W + TIME_BITS;
    localparam int CMP_W  = (TIME_BITS > FADE_W) ? TIME_BITS : FADE_W;

    state_t               state_reg;
    state_t               state_next;
    logic [FADE_W-1:0]    fade_time_reg;
    logic                 gamma_en_reg;
    logic                 attached_reg;
    logic [LEVEL_W-1:0]   target_reg;
    logic [LEVEL_W-1:0]   cur_level_reg;
    logic [LEVEL_W-1:0]   start_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [PROD_W-1:0]    product_reg;
    logic [LEVEL_W-1:0]   lvl_calc_reg;
    logic                 result_valid_reg;
    result_t              result_reg;

    logic                 accept;
    logic                 fade_idle;
    logic                 time_done;
    logic                 dir_down;
    logic [LEVEL_W-1:0]   span;
    logic                 slot_free;
    logic                 ram_we;
    logic                 ram_re;
    logic [LEVEL_W-1:0]   ram_rdata;
    logic                 div_start;
    logic [PROD_W-1:0]    div_quotient;
    div_stat_t            div_stat;

    assign accept    = item_valid && item_ready;
    assign fade_idle = (fade_time_reg == '0) || !attached_reg || (cur_level_reg == target_reg);
    assign time_done = CMP_W'(elapsed_reg) >= CMP_W'(fade_time_reg);
    assign dir_down  = target_reg < start_reg;
    assign span      = dir_down ? (start_reg - target_reg) : (target_reg - start_reg);
    assign slot_free = !result_valid_reg || result_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_time_reg <= '0;
            gamma_en_reg  <= 1'b0;
            attached_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FADE_TIME:       fade_time_reg <= cfg_data[FADE_W-1:0];
                REG_GAMMA_ENABLE:    gamma_en_reg  <= cfg_data[0];
                REG_OUTPUT_ATTACHED: attached_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.func)
                        FUNC_TICK:
                        begin
                            if (!fade_idle)
                            begin
                                state_next = ST_INTERP;
                            end
                        end
                        FUNC_SET:
                        begin
                            if ((fade_time_reg == '0) && attached_reg)
                            begin
                                state_next = ST_LOOK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_INTERP:  state_next = time_done ? ST_CHECK : ST_DIVGO;
            ST_DIVGO:   state_next = ST_DIVWAIT;
            ST_DIVWAIT: state_next = div_stat.done ? ST_CHECK : ST_DIVWAIT;
            ST_CHECK:   state_next = (lvl_calc_reg == cur_level_reg) ? ST_IDLE : ST_LOOK;
            ST_LOOK:    state_next = ST_EMIT;
            ST_EMIT:    state_next = slot_free ? ST_IDLE : ST_EMIT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        item_ready = 1'b0;
        div_start  = 1'b0;
        ram_re     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  item_ready = 1'b1;
            ST_DIVGO: div_start  = 1'b1;
            ST_LOOK:  ram_re     = 1'b1;
            default:  ;
        endcase
    end

    assign ram_we = accept && (item.func == FUNC_GAMMA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Fade state: hold between items, update on transfer and on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            cur_level_reg <= '0;
            start_reg     <= '0;
            elapsed_reg   <= '0;
        end
        else if (accept)
        begin
            case (item.func)
                FUNC_TICK:
                begin
                    if ((CMP_W'(elapsed_reg) < CMP_W'(fade_time_reg)) && (elapsed_reg != '1))
                    begin
                        elapsed_reg <= elapsed_reg + 1'b1;
                    end
                end
                FUNC_SET:
                begin
                    target_reg <= item.level;
                    if ((fade_time_reg == '0) || !attached_reg)
                    begin
                        cur_level_reg <= item.level;
                    end
                    else
                    begin
                        start_reg   <= cur_level_reg;
                        elapsed_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_CHECK)
        begin
            cur_level_reg <= lvl_calc_reg;
        end
    end

    // Interpolation datapath: multiply, then divide, then offset from the start
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INTERP)
        begin
            product_reg  <= PROD_W'(span) * PROD_W'(elapsed_reg);
            lvl_calc_reg <= target_reg;
        end
        else if ((state_reg == ST_DIVWAIT) && div_stat.done)
        begin
            lvl_calc_reg <= dir_down ? (start_reg - div_quotient[LEVEL_W-1:0])
                                     : (start_reg + div_quotient[LEVEL_W-1:0]);
        end
    end

    // Output register: load in emit when free, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_EMIT) && slot_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EMIT) && slot_free)
        begin
            result_reg.duty         <= gamma_en_reg ? ram_rdata : cur_level_reg;
            result_reg.linear_level <= cur_level_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    pfg_div #(
        .DVD_W (PROD_W),
        .DVS_W (FADE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (fade_time_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    pfg_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_gamma_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item.table_index),
        .wdata (item.level),
        .re    (ram_re),
        .raddr (cur_level_reg),
        .rdata (ram_rdata)
    );

    // The partial step never exceeds the span between start and target
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (div_quotient <= PROD_W'(span)))
        else $error("interpolation quotient exceeds span");

    // The divider runs for the whole wait
    a_divwait_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVWAIT) |-> div_stat.busy)
        else $error("divider idle while sequencer waits");

    // A computed level lies between start and target
    a_level_between: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |->
            (dir_down ? ((lvl_calc_reg <= start_reg) && (lvl_calc_reg >= target_reg))
                      : ((lvl_calc_reg >= start_reg) && (lvl_calc_reg <= target_reg))))
        else $error("interpolated level outside fade range");

    // Results only go out to an attached output
    a_emit_attached: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> attached_reg)
        else $error("result emitted while output detached");

endmodule
